// ----- hdl/lcam_pkg.sv -----
// Shared types and constants for the linear classifier argmax core.
package lcam_pkg;

    localparam int DEF_FEATURES = 8;
    localparam int DEF_CLASSES  = 4;
    localparam int MAX_FEATURES = 8;
    localparam int FEAT_W       = 16;
    localparam int WEIGHT_W     = 16;
    localparam int ICPT_W       = 32;
    localparam int PROD_W       = 32;
    localparam int SCORE_W      = 36;
    localparam int CLS_W        = 4;
    localparam int FIDX_W       = 3;

    typedef enum logic [1:0] {
        CMD_WEIGHT   = 2'd0,
        CMD_ICPT     = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ACC,
        ST_ARG,
        ST_OUT
    } state_t;

    // table write broadcast to every cell
    typedef struct packed {
        logic                       we_weight;
        logic                       we_icpt;
        logic [CLS_W-1:0]           cls;
        logic [FIDX_W-1:0]          fidx;
        logic signed [WEIGHT_W-1:0] weight;
        logic signed [ICPT_W-1:0]   icpt;
    } wr_t;

    // sequencing strobes from the controller to the row of cells
    typedef struct packed {
        logic clear_acc;
        logic mac_en;
        logic acc_en;
        logic chain_en;
    } ctl_t;

endpackage

// ----- hdl/lcam_cell.sv -----
// One class cell: weight row, intercept, multiply-accumulate and one argmax compare stage.
module lcam_cell #(
    parameter int FEATURES = lcam_pkg::DEF_FEATURES,
    parameter int CLASS_ID = 0,
    parameter int FIW      = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lcam_pkg::wr_t                         wr,
    input  lcam_pkg::ctl_t                        ctl,
    input  logic [FIW-1:0]                        feat_idx,
    input  logic signed [lcam_pkg::FEAT_W-1:0]    feat,
    input  logic signed [lcam_pkg::SCORE_W-1:0]   best_in,
    input  logic [lcam_pkg::CLS_W-1:0]            idx_in,
    output logic signed [lcam_pkg::SCORE_W-1:0]   best_out,
    output logic [lcam_pkg::CLS_W-1:0]            idx_out
);
    import lcam_pkg::*;

    logic signed [WEIGHT_W-1:0] w_reg [FEATURES];
    logic signed [ICPT_W-1:0]   icpt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SCORE_W-1:0]  acc_reg, acc_next;
    logic signed [SCORE_W-1:0]  best_reg, best_next;
    logic [CLS_W-1:0]           idx_reg, idx_next;
    logic                       row_hit;

    assign row_hit = (wr.cls == CLS_W'(CLASS_ID));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FEATURES; i++) begin
                w_reg[i] <= '0;
            end
            icpt_reg <= '0;
        end else begin
            if (wr.we_weight && row_hit && (32'(wr.fidx) < FEATURES)) begin
                w_reg[wr.fidx[FIW-1:0]] <= wr.weight;
            end
            if (wr.we_icpt && row_hit) begin
                icpt_reg <= wr.icpt;
            end
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear_acc) begin
            acc_next = {{(SCORE_W-ICPT_W){icpt_reg[ICPT_W-1]}}, icpt_reg};
        end else if (ctl.acc_en) begin
            acc_next = acc_reg + {{(SCORE_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // first cell seeds the chain; later cells take their own score only if strictly larger
    always_comb begin
        best_next = best_reg;
        idx_next  = idx_reg;
        if (ctl.chain_en) begin
            if ((CLASS_ID == 0) || (acc_reg > best_in)) begin
                best_next = acc_reg;
                idx_next  = CLS_W'(CLASS_ID);
            end else begin
                best_next = best_in;
                idx_next  = idx_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mac_en) begin
            prod_reg <= feat * w_reg[feat_idx];
        end
        acc_reg  <= acc_next;
        best_reg <= best_next;
        idx_reg  <= idx_next;
    end

    assign best_out = best_reg;
    assign idx_out  = idx_reg;

endmodule

// ----- hdl/lcam_ctrl.sv -----
// Sequencer for the cell row: feature steps, final add, argmax chain drain, result hold.
module lcam_ctrl #(
    parameter int FEATURES = lcam_pkg::DEF_FEATURES,
    parameter int CLASSES  = lcam_pkg::DEF_CLASSES,
    parameter int CNTW     = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_acc,
    input  logic            is_classify,
    input  logic            out_acc,
    output lcam_pkg::ctl_t  ctl,
    output logic [CNTW-1:0] cnt,
    output logic            busy_n,
    output logic            res_valid
);
    import lcam_pkg::*;

    state_t          state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_acc) begin
                    state_next = is_classify ? ST_MAC : ST_OUT;
                end
            end
            ST_MAC: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(FEATURES-1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cnt_next   = '0;
                state_next = ST_ARG;
            end
            ST_ARG: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(CLASSES-1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl       = '0;
        busy_n    = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                busy_n        = 1'b1;
                ctl.clear_acc = in_acc;
            end
            ST_MAC: begin
                ctl.mac_en = 1'b1;
                ctl.acc_en = (cnt_reg != '0);
            end
            ST_ACC:  ctl.acc_en   = 1'b1;
            ST_ARG:  ctl.chain_en = 1'b1;
            ST_OUT:  res_valid    = 1'b1;
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

// ----- hdl/linear_classifier_argmax_core.sv -----
// Top level of the linear classifier: input capture, cell row, result channel.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | class, feature idx, load value, feats   | command
//  m_      | out | predicted class, best score             | is_prediction
//
// A load's result is valid in the cycle after acceptance. A classify steps one feature
// per cycle through each cell's multiplier, then one closing add, then passes the
// scores cell by cell along the argmax chain.
// One item at a time; s_tready is low from acceptance until the result is taken.
// Reset (aresetn, synchronous) clears all weights and intercepts to zero at once.
module linear_classifier_argmax_core #(
    parameter int FEATURES = lcam_pkg::DEF_FEATURES,
    parameter int CLASSES  = lcam_pkg::DEF_CLASSES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // class_index[3:0], feature_index[6:4], load_value[38:7], feature_0..7 [166:39], pad
    input  logic [167:0] s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // predicted_class[3:0], best_score[39:4]
    output logic [39:0]  m_tdata,
    // is_prediction[0]
    output logic         m_tuser
);
    import lcam_pkg::*;

    localparam int MAXN = (FEATURES > CLASSES) ? FEATURES : CLASSES;
    localparam int CNTW = $clog2(MAXN + 1);
    localparam int FIW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;

    logic                       in_acc, out_acc, busy_n, res_valid;
    ctl_t                       ctl;
    logic [CNTW-1:0]            cnt;
    wr_t                        wr;
    cmd_t                       cmd;
    logic signed [ICPT_W-1:0]   lv;
    logic signed [WEIGHT_W-1:0] w_sat;
    logic signed [FEAT_W-1:0]   feat_reg [FEATURES];
    logic                       pred_reg;
    logic signed [SCORE_W-1:0]  best_ch [CLASSES];
    logic [CLS_W-1:0]           idx_ch  [CLASSES];
    logic [CLS_W-1:0]           res_cls;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign cmd     = cmd_t'(s_tuser);
    assign lv      = s_tdata[38:7];

    always_comb begin
        if (lv > 32'sd32767) begin
            w_sat = 16'sh7fff;
        end else if (lv < -32'sd32768) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = lv[WEIGHT_W-1:0];
        end
    end

    always_comb begin
        wr.we_weight = in_acc && (cmd == CMD_WEIGHT);
        wr.we_icpt   = in_acc && (cmd == CMD_ICPT);
        wr.cls       = s_tdata[3:0];
        wr.fidx      = s_tdata[6:4];
        wr.weight    = w_sat;
        wr.icpt      = lv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pred_reg <= 1'b0;
        end else if (in_acc) begin
            pred_reg <= (cmd == CMD_CLASSIFY);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            for (int f = 0; f < FEATURES; f++) begin
                feat_reg[f] <= s_tdata[39 + f*FEAT_W +: FEAT_W];
            end
        end
    end

    lcam_ctrl #(
        .FEATURES (FEATURES),
        .CLASSES  (CLASSES),
        .CNTW     (CNTW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_acc      (in_acc),
        .is_classify (cmd == CMD_CLASSIFY),
        .out_acc     (out_acc),
        .ctl         (ctl),
        .cnt         (cnt),
        .busy_n      (busy_n),
        .res_valid   (res_valid)
    );

    for (genvar c = 0; c < CLASSES; c++) begin : g_cell
        lcam_cell #(
            .FEATURES (FEATURES),
            .CLASS_ID (c),
            .FIW      (FIW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr       (wr),
            .ctl      (ctl),
            .feat_idx (cnt[FIW-1:0]),
            .feat     (feat_reg[cnt[FIW-1:0]]),
            .best_in  ((c == 0) ? best_ch[0] : best_ch[(c == 0) ? 0 : c-1]),
            .idx_in   ((c == 0) ? idx_ch[0]  : idx_ch[(c == 0) ? 0 : c-1]),
            .best_out (best_ch[c]),
            .idx_out  (idx_ch[c])
        );
    end

    // single class: the result is the sign decision rather than an index
    assign res_cls = (CLASSES == 1) ? ((best_ch[CLASSES-1] > 0) ? CLS_W'(1) : CLS_W'(0))
                                    : idx_ch[CLASSES-1];

    assign s_tready = busy_n;
    assign m_tvalid = res_valid;
    assign m_tuser  = pred_reg;
    assign m_tdata  = pred_reg ? {best_ch[CLASSES-1], res_cls} : '0;

`ifndef NO_ASSERTIONS
    a_no_accept_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_result_excl_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("result pending while input is ready");

    a_ack_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("load acknowledgement carries data");

    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (cmd != CMD_CLASSIFY)) |=> m_tvalid)
        else $error("load acknowledgement late");
`endif

endmodule

// ----- bench/tb.sv -----
// Testbench for the linear classifier argmax core: scoreboard class and stream drivers.
`timescale 1ns / 100ps

class score_board;
    logic signed [15:0] weights [4][8];
    logic signed [31:0] icpts [4];
    logic [40:0] pending [$];
    int errors;
    int shown;

    function new();
        foreach (weights[c, f]) weights[c][f] = '0;
        foreach (icpts[c]) icpts[c] = '0;
        errors = 0;
        shown = 0;
    endfunction

    // note an accepted input transaction and queue its expected result
    function void note_input(lcam_pkg::cmd_t cmd, logic [167:0] data);
        logic [3:0] cls;
        logic [2:0] fi;
        logic signed [31:0] lv;
        logic signed [63:0] s;
        logic signed [63:0] best;
        logic [3:0] best_c;
        logic signed [15:0] ft;
        cls = data[3:0];
        fi = data[6:4];
        lv = data[38:7];
        best = 0;
        best_c = 0;
        case (cmd)
            lcam_pkg::CMD_WEIGHT: begin
                if (cls < 4) begin
                    if (lv > 32767) weights[cls][fi] = 16'sd32767;
                    else if (lv < -32768) weights[cls][fi] = -16'sd32768;
                    else weights[cls][fi] = lv[15:0];
                end
                pending.push_back({1'b0, 4'd0, 36'd0});
            end
            lcam_pkg::CMD_ICPT: begin
                if (cls < 4) icpts[cls] = lv;
                pending.push_back({1'b0, 4'd0, 36'd0});
            end
            lcam_pkg::CMD_CLASSIFY: begin
                for (int c = 0; c < 4; c++) begin
                    s = icpts[c];
                    for (int f = 0; f < 8; f++) begin
                        ft = data[39 + 16*f +: 16];
                        s += ft * weights[c][f];
                    end
                    if (c == 0 || s > best) begin
                        best = s;
                        best_c = c;
                    end
                end
                pending.push_back({1'b1, best_c, best[35:0]});
            end
            default: pending.push_back({1'b0, 4'd0, 36'd0});
        endcase
    endfunction

    function void check_result(logic user, logic [39:0] data);
        logic [40:0] exp_v;
        if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("unexpected result: user=%0d data=%h", user, data);
            end
            return;
        end
        exp_v = pending.pop_front();
        if (exp_v[40] !== user || exp_v[39:36] !== data[3:0] ||
                exp_v[35:0] !== data[39:4]) begin
            errors++;
            if (shown < 10) begin
                shown++;
                $display("mismatch: exp pred=%0d cls=%0d score=%0d, got pred=%0d cls=%0d score=%0d",
                    exp_v[40], exp_v[39:36], $signed(exp_v[35:0]),
                    user, data[3:0], $signed(data[39:4]));
            end
        end
    endfunction
endclass

module tb;
    import lcam_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [39:0] m_tdata;
    logic m_tuser;

    score_board sb;
    bit sent_all = 0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    linear_classifier_argmax_core dut (.*);

    function automatic logic [31:0] rand_load();
        case ($urandom_range(0, 4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535) - 32768;
            3: return $urandom_range(0, 32767) - 16384;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_feat();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // tvalid is dropped only when a gap follows, so it never gets two updates in one step
    task automatic send(cmd_t cmd, logic [3:0] cls, logic [2:0] fi,
                        logic [31:0] lv, logic [127:0] feats);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, feats, lv, fi, cls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(cmd, {1'b0, feats, lv, fi, cls});
    endtask

    function automatic logic [127:0] rand_feats();
        logic [127:0] v;
        for (int f = 0; f < 8; f++) v[16*f +: 16] = rand_feat();
        return v;
    endfunction

    // receiver with random stalls
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tuser, m_tdata);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: classify on cleared tables, extremes, out-of-range and unused
        send(CMD_CLASSIFY, 0, 0, 0, rand_feats());
        send(CMD_WEIGHT, 0, 0, 32'h7FFFFFFF, '0);
        send(CMD_WEIGHT, 1, 7, 32'h80000000, '0);
        send(CMD_WEIGHT, 3, 3, 32'h00007FFF, '0);
        send(CMD_WEIGHT, 2, 5, 32'hFFFF8000, '0);
        send(CMD_WEIGHT, 4, 1, 32'h1234, '0);
        send(CMD_WEIGHT, 15, 7, 32'h1234, '0);
        send(CMD_ICPT, 3, 0, 32'h7FFFFFFF, '0);
        send(CMD_ICPT, 0, 7, 32'h80000000, '0);
        send(CMD_ICPT, 9, 0, 32'h5555, '0);
        send(CMD_UNUSED, 1, 2, 32'hFFFFFFFF, '1);
        send(CMD_CLASSIFY, 15, 7, 32'hFFFFFFFF, {8{16'h7FFF}});
        send(CMD_CLASSIFY, 0, 0, 0, {8{16'h8000}});
        send(CMD_CLASSIFY, 0, 0, 0, '0);
        // ties: all classes equal
        for (int c = 0; c < 4; c++) begin
            send(CMD_ICPT, c, 0, 32'd0, '0);
            for (int f = 0; f < 8; f++) send(CMD_WEIGHT, c, f, 32'd0, '0);
        end
        send(CMD_CLASSIFY, 0, 0, 0, rand_feats());
        // hold until every expected result has come
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        for (int i = 0; i < 1300; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send(CMD_WEIGHT, $urandom_range(0, 4), $urandom,
                                 rand_load(), rand_feats());
                4: send(CMD_ICPT, $urandom_range(0, 4), $urandom, rand_load(),
                        rand_feats());
                5: send(CMD_UNUSED, $urandom, $urandom, $urandom, rand_feats());
                default: send(CMD_CLASSIFY, $urandom, $urandom, $urandom,
                              rand_feats());
            endcase
        end
        s_tvalid <= 0;
        sent_all = 1;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- linear_classifier_argmax_core.f -----
hdl/lcam_pkg.sv
hdl/lcam_cell.sv
hdl/lcam_ctrl.sv
hdl/linear_classifier_argmax_core.sv
bench/tb.sv
